>>> rtl/btfc_pkg.sv
// ----------------------------------------------------------------------------
// btfc_pkg
// Shared types, constants and helpers for the boundary-tag free coalescer:
// word layouts, header memory word, controller states, datapath operations.
// ----------------------------------------------------------------------------
package btfc_pkg;

    localparam int HEAP_UNITS = 4096;
    localparam int ADDR_W     = 12;
    localparam int SIZE_W     = 13;
    localparam int SUM_W      = 14;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_READ     = 2'd1,
        CMD_FREE     = 2'd2,
        CMD_SET_HEAD = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size_units;
        logic [SIZE_W-1:0] prev_size_units;
        logic              is_free;
        logic [ADDR_W-1:0] link_prev_in;
        logic [ADDR_W-1:0] link_next_in;
        logic              head_valid_in;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [SIZE_W-1:0] result_size;
        logic [SIZE_W-1:0] result_prev_size;
        logic              result_free;
        logic [ADDR_W-1:0] result_link_prev;
        logic [ADDR_W-1:0] result_link_next;
        logic              merged_following;
        logic              merged_preceding;
        logic [ADDR_W-1:0] head_addr;
        logic              head_valid_out;
    } rsp_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] prior_size;
        logic              free;
        logic [ADDR_W-1:0] link_prev;
        logic [ADDR_W-1:0] link_next;
    } hdr_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ_RD,
        ST_READ_CAP,
        ST_SET_HEAD,
        ST_FREE_C_RD,
        ST_FREE_C_CAP,
        ST_FREE_N_CAP,
        ST_FREE_P_CHK,
        ST_FREE_P_CAP,
        ST_M_T_RD,
        ST_M_T_WR,
        ST_M_LO_RD,
        ST_M_LO_WR,
        ST_M_LP_RD,
        ST_M_LP_WR,
        ST_M_LN_RD,
        ST_M_LN_WR,
        ST_M_HEAD,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_WRITE,
        OP_RD_A,
        OP_READ_CAP,
        OP_SET_HEAD,
        OP_C_CAP,
        OP_N_CAP,
        OP_P_CHK,
        OP_P_CAP,
        OP_T_RD,
        OP_T_WR,
        OP_LO_RD,
        OP_LO_WR,
        OP_LP_RD,
        OP_LP_WR,
        OP_LN_RD,
        OP_LN_WR,
        OP_HEAD,
        OP_FIN_RD,
        OP_FIN_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t req_cmd;
        logic a_ok;
        logic n_ok;
        logic rd_free;
        logic t_ok;
        logic lp_ok;
        logic ln_ok;
        logic p_ok;
        logic out_free;
    } dp_stat_t;

    function automatic logic in_heap(input logic [SUM_W-1:0] a);
        return a < SUM_W'(HEAP_UNITS);
    endfunction

    function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_W] ? {SIZE_W{1'b1}} : s[SIZE_W-1:0];
    endfunction

endpackage

>>> rtl/boundary_tag_free_coalescer.sv
// ----------------------------------------------------------------------------
// boundary_tag_free_coalescer
// Chunk headers live in one single-port memory with registered read, one
// memory access per cycle, and every header update of a free is a read
// followed by a write. A free probes the header of each neighbor that can
// exist (a following chunk inside the heap, a preceding chunk whose offset
// stays inside the heap), absorbs each free neighbor and, when the chunk
// after the merged one lies in the heap, updates its prior size. The result
// register lets a new word start while the previous result waits; a command
// whose result is done holds until that register is taken. No clearing pass
// after reset.
// ----------------------------------------------------------------------------
module boundary_tag_free_coalescer
    import btfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    btfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    btfc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> rtl/btfc_ctrl.sv
// ----------------------------------------------------------------------------
// btfc_ctrl
// Sequencer: walks each command through its header memory accesses and
// issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
module btfc_ctrl
    import btfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   phase_reg;
    logic   phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        req_ready    = 1'b0;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = OP_LATCH;
                    case (stat.req_cmd)
                        CMD_WRITE:    state_next = ST_WRITE;
                        CMD_READ:     state_next = ST_READ_RD;
                        CMD_FREE:     state_next = ST_FREE_C_RD;
                        CMD_SET_HEAD: state_next = ST_SET_HEAD;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.op     = OP_WRITE;
                state_next = ST_DONE;
            end
            ST_READ_RD:
            begin
                cmd.op     = OP_RD_A;
                state_next = ST_READ_CAP;
            end
            ST_READ_CAP:
            begin
                cmd.op     = OP_READ_CAP;
                state_next = ST_DONE;
            end
            ST_SET_HEAD:
            begin
                cmd.op     = OP_SET_HEAD;
                state_next = ST_DONE;
            end
            ST_FREE_C_RD:
            begin
                if (stat.a_ok)
                begin
                    cmd.op     = OP_RD_A;
                    state_next = ST_FREE_C_CAP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FREE_C_CAP:
            begin
                cmd.op     = OP_C_CAP;
                state_next = stat.n_ok ? ST_FREE_N_CAP : ST_FREE_P_CHK;
            end
            ST_FREE_N_CAP:
            begin
                cmd.op = OP_N_CAP;
                if (stat.rd_free)
                begin
                    phase_next = 1'b0;
                    state_next = ST_M_T_RD;
                end
                else
                begin
                    state_next = ST_FREE_P_CHK;
                end
            end
            ST_FREE_P_CHK:
            begin
                cmd.op     = OP_P_CHK;
                state_next = stat.p_ok ? ST_FREE_P_CAP : ST_FIN_RD;
            end
            ST_FREE_P_CAP:
            begin
                cmd.op = OP_P_CAP;
                if (stat.rd_free)
                begin
                    phase_next = 1'b1;
                    state_next = ST_M_T_RD;
                end
                else
                begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_M_T_RD:
            begin
                cmd.op     = OP_T_RD;
                state_next = stat.t_ok ? ST_M_T_WR : ST_M_LO_RD;
            end
            ST_M_T_WR:
            begin
                cmd.op     = OP_T_WR;
                state_next = ST_M_LO_RD;
            end
            ST_M_LO_RD:
            begin
                cmd.op     = OP_LO_RD;
                state_next = ST_M_LO_WR;
            end
            ST_M_LO_WR:
            begin
                cmd.op = OP_LO_WR;
                if (stat.lp_ok)
                begin
                    state_next = ST_M_LP_RD;
                end
                else if (stat.ln_ok)
                begin
                    state_next = ST_M_LN_RD;
                end
                else
                begin
                    state_next = ST_M_HEAD;
                end
            end
            ST_M_LP_RD:
            begin
                cmd.op     = OP_LP_RD;
                state_next = ST_M_LP_WR;
            end
            ST_M_LP_WR:
            begin
                cmd.op     = OP_LP_WR;
                state_next = stat.ln_ok ? ST_M_LN_RD : ST_M_HEAD;
            end
            ST_M_LN_RD:
            begin
                cmd.op     = OP_LN_RD;
                state_next = ST_M_LN_WR;
            end
            ST_M_LN_WR:
            begin
                cmd.op     = OP_LN_WR;
                state_next = ST_M_HEAD;
            end
            ST_M_HEAD:
            begin
                cmd.op     = OP_HEAD;
                state_next = phase_reg ? ST_FIN_RD : ST_FREE_P_CHK;
            end
            ST_FIN_RD:
            begin
                cmd.op     = OP_FIN_RD;
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR:
            begin
                cmd.op     = OP_FIN_WR;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/btfc_dpath.sv
// ----------------------------------------------------------------------------
// btfc_dpath
// Header memory (single port, registered read), working registers of the
// merge, free-list head and the output word register.
// ----------------------------------------------------------------------------
module btfc_dpath
    import btfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    output rsp_t     rsp,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat
);

    hdr_t mem [HEAP_UNITS];

    hdr_t              rdata_reg;
    req_t              in_reg;
    rsp_t              res_reg;
    rsp_t              out_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] head_addr_reg;
    logic              head_valid_reg;
    logic [SIZE_W-1:0] c_size_reg;
    logic [SIZE_W-1:0] c_ps_reg;
    logic [ADDR_W-1:0] n_addr_reg;
    logic [ADDR_W-1:0] p_addr_reg;
    logic [ADDR_W-1:0] lo_addr_reg;
    logic [SIZE_W-1:0] lo_size_reg;
    logic [ADDR_W-1:0] hi_addr_reg;
    logic [SIZE_W-1:0] hi_size_reg;
    logic [ADDR_W-1:0] f_addr_reg;
    logic [ADDR_W-1:0] lnk_prev_reg;
    logic [ADDR_W-1:0] lnk_next_reg;
    logic [ADDR_W-1:0] merged_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    hdr_t              mem_wdata;
    logic [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]  t_sum;
    logic [ADDR_W-1:0] p_calc;
    logic [SIZE_W-1:0] lo_sum;
    rsp_t              out_word;
    rsp_t              start_word;

    assign n_sum  = SUM_W'(in_reg.addr) + SUM_W'(rdata_reg.size);
    assign t_sum  = SUM_W'(hi_addr_reg) + SUM_W'(hi_size_reg);
    assign p_calc = in_reg.addr - c_ps_reg[ADDR_W-1:0];
    assign lo_sum = sat_add(rdata_reg.size, hi_size_reg);

    assign stat.req_cmd  = req.command;
    assign stat.a_ok     = in_heap(SUM_W'(in_reg.addr));
    assign stat.n_ok     = (rdata_reg.size != '0) && in_heap(n_sum);
    assign stat.rd_free  = rdata_reg.free;
    assign stat.t_ok     = in_heap(t_sum);
    assign stat.lp_ok    = in_heap(SUM_W'(lnk_prev_reg));
    assign stat.ln_ok    = in_heap(SUM_W'(lnk_next_reg));
    assign stat.p_ok     = (c_ps_reg != '0) && (c_ps_reg <= SIZE_W'(in_reg.addr));
    assign stat.out_free = !out_valid_reg || rsp_ready;

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        out_word                = res_reg;
        out_word.head_addr      = head_addr_reg;
        out_word.head_valid_out = head_valid_reg;
        start_word              = '0;
        start_word.result_addr  = req.addr;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = in_reg.addr;
        mem_wdata = rdata_reg;
        case (cmd.op)
            OP_WRITE:
            begin
                mem_we               = stat.a_ok;
                mem_wdata.size       = in_reg.size_units;
                mem_wdata.prior_size = in_reg.prev_size_units;
                mem_wdata.free       = in_reg.is_free;
                mem_wdata.link_prev  = in_reg.link_prev_in;
                mem_wdata.link_next  = in_reg.link_next_in;
            end
            OP_C_CAP:
            begin
                mem_addr = n_sum[ADDR_W-1:0];
            end
            OP_N_CAP:
            begin
                mem_addr       = n_addr_reg;
                mem_we         = rdata_reg.free;
                mem_wdata.free = 1'b0;
            end
            OP_P_CHK:
            begin
                mem_addr = p_calc;
            end
            OP_P_CAP:
            begin
                mem_addr       = p_addr_reg;
                mem_we         = rdata_reg.free;
                mem_wdata.free = 1'b0;
            end
            OP_T_RD:
            begin
                mem_addr = t_sum[ADDR_W-1:0];
            end
            OP_T_WR:
            begin
                mem_addr             = t_sum[ADDR_W-1:0];
                mem_we               = 1'b1;
                mem_wdata.prior_size = sat_add(rdata_reg.prior_size, lo_size_reg);
            end
            OP_LO_RD:
            begin
                mem_addr = lo_addr_reg;
            end
            OP_LO_WR:
            begin
                mem_addr       = lo_addr_reg;
                mem_we         = 1'b1;
                mem_wdata.size = lo_sum;
            end
            OP_LP_RD:
            begin
                mem_addr = lnk_prev_reg;
            end
            OP_LP_WR:
            begin
                mem_addr            = lnk_prev_reg;
                mem_we              = 1'b1;
                mem_wdata.link_next = lnk_next_reg;
            end
            OP_LN_RD:
            begin
                mem_addr = lnk_next_reg;
            end
            OP_LN_WR:
            begin
                mem_addr            = lnk_next_reg;
                mem_we              = 1'b1;
                mem_wdata.link_prev = lnk_prev_reg;
            end
            OP_FIN_RD:
            begin
                mem_addr = merged_reg;
            end
            OP_FIN_WR:
            begin
                mem_addr       = merged_reg;
                mem_we         = 1'b1;
                mem_wdata.free = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= out_word;
        end
        case (cmd.op)
            OP_LATCH:
            begin
                in_reg  <= req;
                res_reg <= start_word;
            end
            OP_WRITE:
            begin
                if (stat.a_ok)
                begin
                    res_reg.result_size      <= in_reg.size_units;
                    res_reg.result_prev_size <= in_reg.prev_size_units;
                    res_reg.result_free      <= in_reg.is_free;
                    res_reg.result_link_prev <= in_reg.link_prev_in;
                    res_reg.result_link_next <= in_reg.link_next_in;
                end
            end
            OP_READ_CAP:
            begin
                if (stat.a_ok)
                begin
                    res_reg.result_size      <= rdata_reg.size;
                    res_reg.result_prev_size <= rdata_reg.prior_size;
                    res_reg.result_free      <= rdata_reg.free;
                    res_reg.result_link_prev <= rdata_reg.link_prev;
                    res_reg.result_link_next <= rdata_reg.link_next;
                end
            end
            OP_C_CAP:
            begin
                c_size_reg <= rdata_reg.size;
                c_ps_reg   <= rdata_reg.prior_size;
                n_addr_reg <= n_sum[ADDR_W-1:0];
                merged_reg <= in_reg.addr;
            end
            OP_N_CAP:
            begin
                if (rdata_reg.free)
                begin
                    lo_addr_reg              <= in_reg.addr;
                    lo_size_reg              <= c_size_reg;
                    hi_addr_reg              <= n_addr_reg;
                    hi_size_reg              <= rdata_reg.size;
                    f_addr_reg               <= n_addr_reg;
                    lnk_prev_reg             <= rdata_reg.link_prev;
                    lnk_next_reg             <= rdata_reg.link_next;
                    res_reg.merged_following <= 1'b1;
                end
            end
            OP_LO_WR:
            begin
                if (lo_addr_reg == in_reg.addr)
                begin
                    c_size_reg <= lo_sum;
                end
            end
            OP_P_CHK:
            begin
                p_addr_reg <= p_calc;
            end
            OP_P_CAP:
            begin
                if (rdata_reg.free)
                begin
                    lo_addr_reg              <= p_addr_reg;
                    lo_size_reg              <= rdata_reg.size;
                    hi_addr_reg              <= in_reg.addr;
                    hi_size_reg              <= c_size_reg;
                    f_addr_reg               <= p_addr_reg;
                    lnk_prev_reg             <= rdata_reg.link_prev;
                    lnk_next_reg             <= rdata_reg.link_next;
                    merged_reg               <= p_addr_reg;
                    res_reg.merged_preceding <= 1'b1;
                end
            end
            OP_FIN_WR:
            begin
                res_reg.result_addr      <= merged_reg;
                res_reg.result_size      <= rdata_reg.size;
                res_reg.result_prev_size <= rdata_reg.prior_size;
                res_reg.result_free      <= 1'b1;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_addr_reg  <= '0;
            head_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == OP_SET_HEAD)
            begin
                head_addr_reg  <= in_reg.addr;
                head_valid_reg <= in_reg.head_valid_in;
            end
            else if (cmd.op == OP_HEAD && head_valid_reg && head_addr_reg == f_addr_reg)
            begin
                if (lnk_next_reg != f_addr_reg)
                begin
                    head_addr_reg <= lnk_next_reg;
                end
                else
                begin
                    head_valid_reg <= 1'b0;
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the boundary-tag free coalescer. Request words are
// queued up front: a short directed set for the extremes and the odd cases,
// then random free sequences in which every header a free can reach is
// written first, mixed with stray reads, writes and head updates. A shadow
// heap predicts each response at acceptance, and the monitor compares every
// response field by field. Both sides idle at random; the receiver holds off
// once for a long stretch and the sender waits for a full drain after the
// directed set and again partway through the random sequences.
module tb_top;
    import btfc_pkg::*;

    localparam int unsigned SIZE_CAP = (1 << SIZE_W) - 1;

    typedef struct {
        req_t        word;
        int unsigned gap;
        bit          drain;
    } drive_slot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    drive_slot_t       req_words[$];
    rsp_t              pending_results[$];
    hdr_t              heap_hdr[HEAP_UNITS];
    logic [ADDR_W-1:0] list_head = '0;
    logic              list_live = 1'b0;

    bit                written[HEAP_UNITS];
    int unsigned       written_addrs[$];
    hdr_t              plan_hdr[int unsigned];
    int unsigned       plan_addrs[$];
    int unsigned       words_made = 0;
    int unsigned       calm_left = 0;
    bit                tx_calm = 1'b0;

    drive_slot_t       slot;
    int unsigned       gap_left = 0;
    rsp_t              want;
    int unsigned       results_taken = 0;
    int unsigned       stall_left = 0;
    bit                rx_calm = 1'b0;
    int unsigned       mismatch_count = 0;

    boundary_tag_free_coalescer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic logic [SIZE_W-1:0] size_sum(input int unsigned a, input int unsigned b);
        return (a + b > SIZE_CAP) ? SIZE_W'(SIZE_CAP) : SIZE_W'(a + b);
    endfunction

    function automatic void raise_prev(input int unsigned at, input int unsigned amount);
        if (at < HEAP_UNITS)
            heap_hdr[ADDR_W'(at)].prior_size =
                size_sum(32'(heap_hdr[ADDR_W'(at)].prior_size), amount);
    endfunction

    function automatic void unlink_free(input logic [ADDR_W-1:0] x);
        logic [ADDR_W-1:0] lp;
        logic [ADDR_W-1:0] ln;
        lp = heap_hdr[x].link_prev;
        ln = heap_hdr[x].link_next;
        heap_hdr[lp].link_next = ln;
        heap_hdr[ln].link_prev = lp;
        if (list_live && list_head == x)
        begin
            if (ln != x)
                list_head = ln;
            else
                list_live = 1'b0;
        end
    endfunction

    function automatic rsp_t heap_command_result(input req_t w);
        rsp_t              r;
        logic [ADDR_W-1:0] c;
        logic [ADDR_W-1:0] m;
        int unsigned       nx;
        logic [ADDR_W-1:0] px;
        logic [SIZE_W-1:0] ps;
        r = '0;
        r.result_addr = w.addr;
        case (w.command)
            CMD_WRITE, CMD_READ:
            begin
                if (w.command == CMD_WRITE)
                    heap_hdr[w.addr] = hdr_t'{w.size_units, w.prev_size_units, w.is_free,
                                              w.link_prev_in, w.link_next_in};
                r.result_size      = heap_hdr[w.addr].size;
                r.result_prev_size = heap_hdr[w.addr].prior_size;
                r.result_free      = heap_hdr[w.addr].free;
                r.result_link_prev = heap_hdr[w.addr].link_prev;
                r.result_link_next = heap_hdr[w.addr].link_next;
            end
            CMD_SET_HEAD:
            begin
                list_head = w.addr;
                list_live = w.head_valid_in;
            end
            CMD_FREE:
            begin
                c = w.addr;
                m = c;
                nx = 32'(c) + 32'(heap_hdr[c].size);
                if (nx != 32'(c) && nx < HEAP_UNITS && heap_hdr[ADDR_W'(nx)].free)
                begin
                    heap_hdr[ADDR_W'(nx)].free = 1'b0;
                    raise_prev(nx + 32'(heap_hdr[ADDR_W'(nx)].size), 32'(heap_hdr[c].size));
                    heap_hdr[c].size = size_sum(32'(heap_hdr[c].size),
                                                32'(heap_hdr[ADDR_W'(nx)].size));
                    unlink_free(ADDR_W'(nx));
                    r.merged_following = 1'b1;
                end
                ps = heap_hdr[c].prior_size;
                if (ps != '0 && ps <= SIZE_W'(c))
                begin
                    px = c - ADDR_W'(ps);
                    if (heap_hdr[px].free)
                    begin
                        heap_hdr[px].free = 1'b0;
                        raise_prev(32'(c) + 32'(heap_hdr[c].size), 32'(heap_hdr[px].size));
                        heap_hdr[px].size = size_sum(32'(heap_hdr[px].size),
                                                     32'(heap_hdr[c].size));
                        m = px;
                        unlink_free(px);
                        r.merged_preceding = 1'b1;
                    end
                end
                heap_hdr[m].free   = 1'b1;
                r.result_addr      = m;
                r.result_size      = heap_hdr[m].size;
                r.result_prev_size = heap_hdr[m].prior_size;
                r.result_free      = 1'b1;
            end
            default:
            begin
                r = '0;
            end
        endcase
        r.head_addr      = list_head;
        r.head_valid_out = list_live;
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic req_t noise_word(input cmd_t cmd, input int unsigned addr);
        req_t w;
        w.command         = cmd;
        w.addr            = ADDR_W'(addr);
        w.size_units      = SIZE_W'($urandom);
        w.prev_size_units = SIZE_W'($urandom);
        w.is_free         = 1'($urandom);
        w.link_prev_in    = ADDR_W'($urandom);
        w.link_next_in    = ADDR_W'($urandom);
        w.head_valid_in   = 1'($urandom);
        return w;
    endfunction

    function automatic logic [ADDR_W-1:0] near_link(input int unsigned a);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return ADDR_W'(a);
        if (r < 75)
            return ADDR_W'(a + $urandom_range(0, 96) - 48);
        return ADDR_W'($urandom);
    endfunction

    function automatic hdr_t rand_hdr(input int unsigned a, input int unsigned pct_free);
        hdr_t        h;
        int unsigned r;
        r = $urandom_range(0, 99);
        h.size = (r < 5) ? '0 : (r < 12) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(1, 48));
        r = $urandom_range(0, 99);
        h.prior_size = (r < 12) ? '0 : (r < 18) ? SIZE_W'($urandom)
                                                : SIZE_W'($urandom_range(1, 48));
        h.free      = ($urandom_range(0, 99) < pct_free);
        h.link_prev = near_link(a);
        h.link_next = near_link(a);
        return h;
    endfunction

    task automatic push_word(input req_t w);
        drive_slot_t s;
        if (calm_left == 0)
        begin
            tx_calm = !tx_calm;
            calm_left = $urandom_range(15, 40);
        end
        calm_left--;
        s.word = w;
        s.gap = tx_calm ? 0 : idle_len();
        s.drain = 1'b0;
        req_words.push_back(s);
        words_made++;
        if (w.command == CMD_WRITE && !written[w.addr])
        begin
            written[w.addr] = 1'b1;
            written_addrs.push_back(32'(w.addr));
        end
    endtask

    task automatic push_drain();
        drive_slot_t s;
        s.word = '0;
        s.gap = 0;
        s.drain = 1'b1;
        req_words.push_back(s);
    endtask

    task automatic put_header(input int unsigned addr, input hdr_t h);
        req_t w;
        w = noise_word(CMD_WRITE, addr);
        w.size_units      = h.size;
        w.prev_size_units = h.prior_size;
        w.is_free         = h.free;
        w.link_prev_in    = h.link_prev;
        w.link_next_in    = h.link_next;
        push_word(w);
    endtask

    task automatic put_head(input int unsigned addr, input bit live);
        req_t w;
        w = noise_word(CMD_SET_HEAD, addr);
        w.head_valid_in = live;
        push_word(w);
    endtask

    task automatic plan_entry(input int unsigned a, input int unsigned pct_free);
        if (!plan_hdr.exists(a))
        begin
            plan_hdr[a] = rand_hdr(a, pct_free);
            plan_addrs.push_back(a);
        end
    endtask

    // write every header the free can reach, maybe set the head, then free and read back up to two of them
    task automatic plan_free_sequence();
        int unsigned c;
        int unsigned nx;
        int unsigned px;
        int unsigned grown;
        hdr_t        hc;
        hdr_t        hn;
        hdr_t        hp;
        plan_hdr.delete();
        plan_addrs.delete();
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                        : $urandom_range(64, HEAP_UNITS - 1);
        plan_entry(c, 20);
        hc = plan_hdr[c];
        grown = 32'(hc.size);
        nx = c + 32'(hc.size);
        if (nx != c && nx < HEAP_UNITS)
        begin
            plan_entry(nx, 70);
            hn = plan_hdr[nx];
            if (hn.free)
            begin
                if (nx + 32'(hn.size) < HEAP_UNITS)
                    plan_entry(nx + 32'(hn.size), 30);
                plan_entry(32'(hn.link_prev), 50);
                plan_entry(32'(hn.link_next), 50);
                grown = 32'(size_sum(32'(hc.size), 32'(hn.size)));
            end
        end
        if (hc.prior_size != '0 && 32'(hc.prior_size) <= c)
        begin
            px = c - 32'(hc.prior_size);
            plan_entry(px, 70);
            hp = plan_hdr[px];
            if (hp.free)
            begin
                if (c + grown < HEAP_UNITS)
                    plan_entry(c + grown, 30);
                plan_entry(32'(hp.link_prev), 50);
                plan_entry(32'(hp.link_next), 50);
            end
        end
        foreach (plan_addrs[i])
            put_header(plan_addrs[i], plan_hdr[plan_addrs[i]]);
        if ($urandom_range(0, 99) < 60)
            put_head(plan_addrs[$urandom_range(0, plan_addrs.size() - 1)],
                     $urandom_range(0, 99) < 85);
        push_word(noise_word(CMD_FREE, c));
        repeat ($urandom_range(0, 2))
            push_word(noise_word(CMD_READ, plan_addrs[$urandom_range(0, plan_addrs.size() - 1)]));
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("response %0d: %s", results_taken, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
            note_failure($sformatf("%s expected %0h, got %0h", name, exp_v, act_v));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            gap_left = 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (req_words.size() == 0)
            begin
                req_valid <= 1'b0;
            end
            else if (req_words[0].drain)
            begin
                req_valid <= 1'b0;
                if (!req_valid && pending_results.size() == 0)
                    void'(req_words.pop_front());
            end
            else
            begin
                slot = req_words.pop_front();
                req <= slot.word;
                req_valid <= 1'b1;
                gap_left = slot.gap;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            pending_results.push_back(heap_command_result(req));
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_taken++;
                if (pending_results.size() == 0)
                begin
                    note_failure("word arrived with nothing expected");
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("result_addr", 16'(want.result_addr), 16'(rsp.result_addr));
                    check_field("result_size", 16'(want.result_size), 16'(rsp.result_size));
                    check_field("result_prev_size", 16'(want.result_prev_size),
                                16'(rsp.result_prev_size));
                    check_field("result_free", 16'(want.result_free), 16'(rsp.result_free));
                    check_field("result_link_prev", 16'(want.result_link_prev),
                                16'(rsp.result_link_prev));
                    check_field("result_link_next", 16'(want.result_link_next),
                                16'(rsp.result_link_next));
                    check_field("merged_following", 16'(want.merged_following),
                                16'(rsp.merged_following));
                    check_field("merged_preceding", 16'(want.merged_preceding),
                                16'(rsp.merged_preceding));
                    check_field("head_addr", 16'(want.head_addr), 16'(rsp.head_addr));
                    check_field("head_valid_out", 16'(want.head_valid_out),
                                16'(rsp.head_valid_out));
                end
                if (results_taken % 50 == 0)
                    rx_calm = !rx_calm;
                // hold off long enough to back up the input side
                if (results_taken == 150)
                    stall_left = 400;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 99) < 30)
            begin
                stall_left = idle_len();
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        put_header(4095, hdr_t'{13'h1fff, 13'h1fff, 1'b1, 12'hfff, 12'hfff});
        push_word(noise_word(CMD_READ, 4095));
        push_word(noise_word(CMD_FREE, 4095));
        put_header(0, hdr_t'{13'd0, 13'd0, 1'b0, 12'd0, 12'd0});
        push_word(noise_word(CMD_FREE, 0));
        put_head(0, 1'b0);
        put_head(4095, 1'b1);

        // merge on both sides, sums saturate, head advances
        put_header(100, hdr_t'{13'd20, 13'd0, 1'b1, 12'd200, 12'd150});
        put_header(120, hdr_t'{13'd30, 13'd20, 1'b0, 12'd0, 12'd0});
        put_header(150, hdr_t'{13'd8180, 13'd30, 1'b1, 12'd100, 12'd200});
        put_header(200, hdr_t'{13'd10, 13'd0, 1'b1, 12'd150, 12'd100});
        put_head(150, 1'b1);
        push_word(noise_word(CMD_FREE, 120));
        push_word(noise_word(CMD_READ, 120));
        push_word(noise_word(CMD_READ, 150));
        push_word(noise_word(CMD_READ, 200));

        // absorb a lone list member, list empties, prior size saturates
        put_header(300, hdr_t'{13'd10, 13'd0, 1'b0, 12'd0, 12'd0});
        put_header(310, hdr_t'{13'd5, 13'd10, 1'b1, 12'd310, 12'd310});
        put_header(315, hdr_t'{13'd7, 13'd8190, 1'b0, 12'd0, 12'd0});
        put_head(310, 1'b1);
        push_word(noise_word(CMD_FREE, 300));
        push_word(noise_word(CMD_READ, 315));
        push_drain();

        while (words_made < 420)
        begin
            if (words_made >= 230 && words_made < 245)
                push_drain();
            if ($urandom_range(0, 99) < 75)
            begin
                plan_free_sequence();
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: push_word(noise_word(CMD_READ,
                                 written_addrs[$urandom_range(0, written_addrs.size() - 1)]));
                    1: put_header($urandom_range(0, HEAP_UNITS - 1),
                                  rand_hdr($urandom_range(0, HEAP_UNITS - 1), 50));
                    default: push_word(noise_word(CMD_SET_HEAD, $urandom));
                endcase
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (req_words.size() != 0 || req_valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> boundary_tag_free_coalescer.f
rtl/btfc_pkg.sv
rtl/btfc_ctrl.sv
rtl/btfc_dpath.sv
rtl/boundary_tag_free_coalescer.sv
tb/sv/tb_top.sv
